[rtl/core/wrpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrpm_pkg: shared definitions of the wheel tachometer
// Field widths, register indexes, reset values and the divider handshake.
// ----------------------------------------------------------------------------
package wrpm_pkg;

	localparam int WHEELS_DEFAULT        = 4;
	localparam int CAPTURE_DEPTH_DEFAULT = 8;
	localparam int MAX_WHEELS            = 4;

	localparam int WHEEL_W = 2;
	localparam int STAMP_W = 16;
	localparam int RPM_W   = 16;
	localparam int NUM_W   = 32;
	localparam int CNT_W   = 8;
	localparam int STALL_W = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int DIV_STEPS  = RPM_W;
	localparam int DIV_STEP_W = $clog2(DIV_STEPS);

	localparam logic [NUM_W-1:0]   RPM_NUMERATOR_RESET = 32'd2520000000;
	localparam logic [STALL_W-1:0] STALL_TICKS_RESET   = 8'd20;
	localparam logic [RPM_W-1:0]   MIN_CHANGE_RESET    = 16'd1;

	localparam logic ACTION_CAPTURE = 1'b0;
	localparam logic ACTION_TICK    = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RPM_NUMERATOR = 2'd0,
		CFG_STALL_TICKS   = 2'd1,
		CFG_MIN_CHANGE    = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] numer;
		logic [RPM_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [RPM_W-1:0] quotient;
	} div_rsp_t;

endpackage

[rtl/core/wrpm_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrpm_ifs: channels of the wheel tachometer
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface wrpm_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [wrpm_pkg::WHEEL_W-1:0] wheel;
	logic [wrpm_pkg::STAMP_W-1:0] timestamp;

	modport source (output valid, action, wheel, timestamp, input ready);
	modport sink (input valid, action, wheel, timestamp, output ready);
endinterface

interface wrpm_out_if;
	logic                       valid;
	logic                       ready;
	logic [wrpm_pkg::RPM_W-1:0] rpm_fl;
	logic [wrpm_pkg::RPM_W-1:0] rpm_fr;
	logic [wrpm_pkg::RPM_W-1:0] rpm_rl;
	logic [wrpm_pkg::RPM_W-1:0] rpm_rr;

	modport source (output valid, rpm_fl, rpm_fr, rpm_rl, rpm_rr, input ready);
	modport sink (input valid, rpm_fl, rpm_fr, rpm_rl, rpm_rr, output ready);
endinterface

interface wrpm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [wrpm_pkg::CFG_IDX_W-1:0]  index;
	logic [wrpm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/wrpm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrpm_div: saturating 32 by 16 bit divider
// Restoring division, one quotient bit per cycle; quotients that do not fit
// in 16 bits, and division by zero, give all ones at once.
// ----------------------------------------------------------------------------
module wrpm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  wrpm_pkg::div_req_t req,
	output wrpm_pkg::div_rsp_t rsp
);

	localparam int RW = wrpm_pkg::RPM_W;

	typedef enum logic [1:0] {
		DV_IDLE = 2'b01,
		DV_RUN  = 2'b10
	} div_state_t;

	div_state_t                        state_q;
	logic [wrpm_pkg::DIV_STEP_W-1:0]   step_q;
	logic                              done_q;
	logic [RW-1:0]                     rem_q;
	logic [RW-1:0]                     quot_q;
	logic [RW-1:0]                     denom_q;

	logic          launch;
	logic          overflow;
	logic [RW:0]   shifted;
	logic [RW:0]   trial;
	logic          fits;

	assign launch   = req.start && (state_q == DV_IDLE);
	assign overflow = req.numer[wrpm_pkg::NUM_W-1:RW] >= req.denom;
	assign shifted  = {rem_q, quot_q[RW-1]};
	assign trial    = shifted - {1'b0, denom_q};
	assign fits     = shifted >= {1'b0, denom_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					if (launch) begin
						if (overflow) begin
							done_q <= 1'b1;
						end else begin
							state_q <= DV_RUN;
							step_q  <= '0;
						end
					end
				end
				DV_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == wrpm_pkg::DIV_STEP_W'(wrpm_pkg::DIV_STEPS - 1)) begin
						state_q <= DV_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			denom_q <= req.denom;
			if (overflow) begin
				quot_q <= '1;
			end else begin
				rem_q  <= req.numer[wrpm_pkg::NUM_W-1:RW];
				quot_q <= req.numer[RW-1:0];
			end
		end else if (state_q == DV_RUN) begin
			rem_q  <= fits ? trial[RW-1:0] : shifted[RW-1:0];
			quot_q <= {quot_q[RW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

[rtl/core/wheel_rpm_from_capture_period.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_rpm_from_capture_period: four-wheel period tachometer
// Collects timer stamps per wheel and turns the last period into rpm on
// every measurement tick, reporting when any wheel has changed enough.
// ----------------------------------------------------------------------------
// A capture item is taken in ST_IDLE and the block stays ready for the next
// item. A tick item walks the wheels one after another: a wheel without two
// stamps goes from ST_WHEEL straight to ST_CMP, and a wheel with a new period
// waits in ST_DIV for the shared divider, which produces one quotient bit per
// cycle or gives all ones at once when the quotient saturates. After the last
// wheel the block waits in ST_FIN for the result register to empty when a
// report is due. Captures are accepted while a report waits to be taken.
module wheel_rpm_from_capture_period #(
	parameter int WHEELS        = wrpm_pkg::WHEELS_DEFAULT,
	parameter int CAPTURE_DEPTH = wrpm_pkg::CAPTURE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	wrpm_in_if.sink    in_ch,
	wrpm_out_if.source out_ch,
	wrpm_cfg_if.sink   cfg
);

	localparam int WW     = (WHEELS > 1) ? $clog2(WHEELS) : 1;
	localparam int WCMP_W = wrpm_pkg::WHEEL_W + 1;
	localparam int RW     = wrpm_pkg::RPM_W;
	localparam int CW     = wrpm_pkg::CNT_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WHEEL = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_CMP   = 5'b01000,
		ST_FIN   = 5'b10000
	} seq_state_t;

	seq_state_t                     state_q;
	logic [WW-1:0]                  w_q;
	logic                           changed_q;
	logic [wrpm_pkg::NUM_W-1:0]     rpm_num_q;
	logic [wrpm_pkg::STALL_W-1:0]   stall_q;
	logic [RW-1:0]                  min_change_q;
	logic [CW-1:0]                  capture_count_q [WHEELS];
	logic [wrpm_pkg::STALL_W-1:0]   quiet_ticks_q [WHEELS];
	logic [RW-1:0]                  current_rpm_q [WHEELS];
	logic [RW-1:0]                  reported_rpm_q [WHEELS];
	logic [wrpm_pkg::STAMP_W-1:0]   newest_stamp_q [WHEELS];
	logic [wrpm_pkg::STAMP_W-1:0]   older_stamp_q [WHEELS];
	logic                           out_valid_q;
	logic [RW-1:0]                  out_rpm_q [wrpm_pkg::MAX_WHEELS];

	logic                           in_fire;
	logic                           wheel_ok;
	logic                           capture_go;
	logic [WW-1:0]                  wsel;
	logic [CW-1:0]                  cnt_rd;
	logic [wrpm_pkg::STALL_W-1:0]   quiet_rd;
	logic [RW-1:0]                  cur_rd;
	logic [RW-1:0]                  rep_rd;
	logic [RW-1:0]                  rpm_delta;
	logic                           has_period;
	logic                           out_free;
	logic                           report_go;
	logic                           last_wheel;
	logic [RW-1:0]                  cur_ext [wrpm_pkg::MAX_WHEELS];
	wrpm_pkg::div_req_t             div_req;
	wrpm_pkg::div_rsp_t             div_rsp;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign wheel_ok    = {1'b0, in_ch.wheel} < WCMP_W'(WHEELS);
	assign wsel        = (state_q == ST_IDLE) ? WW'(in_ch.wheel) : w_q;

	assign cnt_rd   = capture_count_q[wsel];
	assign quiet_rd = quiet_ticks_q[wsel];
	assign cur_rd   = current_rpm_q[wsel];
	assign rep_rd   = reported_rpm_q[wsel];

	assign capture_go = in_fire && (in_ch.action == wrpm_pkg::ACTION_CAPTURE) && wheel_ok
		&& (cnt_rd < CW'(CAPTURE_DEPTH));
	assign has_period = cnt_rd >= CW'(2);
	assign rpm_delta  = (cur_rd >= rep_rd) ? (cur_rd - rep_rd) : (rep_rd - cur_rd);
	assign last_wheel = (w_q == WW'(WHEELS - 1));
	assign out_free   = !out_valid_q || out_ch.ready;
	assign report_go  = (state_q == ST_FIN) && changed_q && out_free;

	assign div_req.start = (state_q == ST_WHEEL) && has_period;
	assign div_req.numer = rpm_num_q;
	assign div_req.denom = newest_stamp_q[wsel] - older_stamp_q[wsel];

	wrpm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_num_q    <= wrpm_pkg::RPM_NUMERATOR_RESET;
			stall_q      <= wrpm_pkg::STALL_TICKS_RESET;
			min_change_q <= wrpm_pkg::MIN_CHANGE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				wrpm_pkg::CFG_RPM_NUMERATOR: rpm_num_q <= cfg.data;
				wrpm_pkg::CFG_STALL_TICKS:   stall_q <= cfg.data[wrpm_pkg::STALL_W-1:0];
				wrpm_pkg::CFG_MIN_CHANGE:    min_change_q <= cfg.data[RW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			w_q       <= '0;
			changed_q <= 1'b0;
			for (int i = 0; i < WHEELS; i++) begin
				capture_count_q[i] <= '0;
				quiet_ticks_q[i]   <= '0;
				current_rpm_q[i]   <= '0;
				reported_rpm_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (capture_go) begin
						capture_count_q[wsel] <= cnt_rd + 1'b1;
					end
					if (in_fire && (in_ch.action == wrpm_pkg::ACTION_TICK)) begin
						state_q   <= ST_WHEEL;
						w_q       <= '0;
						changed_q <= 1'b0;
					end
				end
				ST_WHEEL: begin
					if (has_period) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_CMP;
						if (quiet_rd <= stall_q) begin
							if (quiet_rd != '1) begin
								quiet_ticks_q[wsel] <= quiet_rd + 1'b1;
							end
						end else begin
							current_rpm_q[wsel]   <= '0;
							quiet_ticks_q[wsel]   <= '0;
							capture_count_q[wsel] <= '0;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						current_rpm_q[wsel]   <= div_rsp.quotient;
						quiet_ticks_q[wsel]   <= '0;
						capture_count_q[wsel] <= '0;
						state_q               <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (rpm_delta >= min_change_q) begin
						changed_q <= 1'b1;
					end
					if (last_wheel) begin
						state_q <= ST_FIN;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= ST_WHEEL;
					end
				end
				ST_FIN: begin
					if (!changed_q || out_free) begin
						state_q <= ST_IDLE;
					end
					if (report_go) begin
						for (int i = 0; i < WHEELS; i++) begin
							reported_rpm_q[i] <= current_rpm_q[i];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (capture_go) begin
			older_stamp_q[wsel]  <= newest_stamp_q[wsel];
			newest_stamp_q[wsel] <= in_ch.timestamp;
		end
	end

	for (genvar g = 0; g < wrpm_pkg::MAX_WHEELS; g++) begin : g_ext
		if (g < WHEELS) begin : g_on
			assign cur_ext[g] = current_rpm_q[g];
		end else begin : g_off
			assign cur_ext[g] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report_go) begin
			for (int i = 0; i < wrpm_pkg::MAX_WHEELS; i++) begin
				out_rpm_q[i] <= cur_ext[i];
			end
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.rpm_fl = out_rpm_q[0];
	assign out_ch.rpm_fr = out_rpm_q[1];
	assign out_ch.rpm_rl = out_rpm_q[2];
	assign out_ch.rpm_rr = out_rpm_q[3];

endmodule

[rtl/core/wrpm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrpm_checker: port-level checks of the wheel tachometer
// Watches the item channels and the result channel over time.
// ----------------------------------------------------------------------------
module wrpm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       in_action,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [wrpm_pkg::RPM_W-1:0] out_fl,
	input logic [wrpm_pkg::RPM_W-1:0] out_fr,
	input logic [wrpm_pkg::RPM_W-1:0] out_rl,
	input logic [wrpm_pkg::RPM_W-1:0] out_rr
);

	logic cap_fire;
	logic tick_fire;

	assign cap_fire  = in_valid && in_ready && (in_action == wrpm_pkg::ACTION_CAPTURE);
	assign tick_fire = in_valid && in_ready && (in_action == wrpm_pkg::ACTION_TICK);

	// A capture item never produces a report.
	assert property (@(posedge clk) disable iff (!arst_n)
		cap_fire |=> !$rose(out_valid))
		else $error("report raised after a capture item");

	// The block is ready again in the cycle after a capture.
	assert property (@(posedge clk) disable iff (!arst_n)
		cap_fire |=> in_ready)
		else $error("block not ready after a capture item");

	// A tick keeps the block busy while the wheels are evaluated.
	assert property (@(posedge clk) disable iff (!arst_n)
		tick_fire |=> !in_ready)
		else $error("block ready right after a tick item");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_fl) && $stable(out_fr)
			&& $stable(out_rl) && $stable(out_rr))
		else $error("stalled report changed");

endmodule

bind wheel_rpm_from_capture_period wrpm_checker u_wrpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.in_action(in_ch.action),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_fl   (out_ch.rpm_fl),
	.out_fr   (out_ch.rpm_fr),
	.out_rl   (out_ch.rpm_rl),
	.out_rr   (out_ch.rpm_rr)
);

[tb/sv/wheel_rpm_from_capture_period_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_rpm_from_capture_period_tb: self-checking bench of the wheel tachometer
// A short table of captures and ticks opens the run. Several register settings
// follow, each with a random stream of capture bursts and ticks, most also with
// noise. Every accepted item goes through a local copy of the tachometer, and
// every report is compared field by field with the oldest one still expected.
// ----------------------------------------------------------------------------
module wheel_rpm_from_capture_period_tb;
	import wrpm_pkg::*;

	localparam int WHEELS        = WHEELS_DEFAULT;
	localparam int CAPTURE_DEPTH = CAPTURE_DEPTH_DEFAULT;
	localparam int DRAIN_CYCLES  = 120;
	localparam int STUCK_LIMIT   = 5000;

	typedef struct packed {
		logic [RPM_W-1:0] fl;
		logic [RPM_W-1:0] fr;
		logic [RPM_W-1:0] rl;
		logic [RPM_W-1:0] rr;
	} rpm_report_t;

	typedef struct packed {
		logic               action;
		logic [WHEEL_W-1:0] wheel;
		logic [STAMP_W-1:0] stamp;
		logic               typed;
		logic               report;
		rpm_report_t        rpm;
	} stim_row_t;

	localparam rpm_report_t NO_RPM = '0;

	logic clk;
	logic arst_n;

	wrpm_in_if  in_if ();
	wrpm_out_if out_if ();
	wrpm_cfg_if cfg_if ();

	wheel_rpm_from_capture_period #(
		.WHEELS       (WHEELS),
		.CAPTURE_DEPTH(CAPTURE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_if),
		.out_ch(out_if),
		.cfg   (cfg_if)
	);

	logic [NUM_W-1:0]   numer_cfg;
	logic [STALL_W-1:0] stall_cfg;
	logic [RPM_W-1:0]   min_chg_cfg;

	logic [CNT_W-1:0]   stamp_cnt [WHEELS];
	logic [STAMP_W-1:0] stamp_new [WHEELS];
	logic [STAMP_W-1:0] stamp_old [WHEELS];
	logic [CNT_W-1:0]   quiet_cnt [WHEELS];
	logic [RPM_W-1:0]   wheel_rpm [WHEELS];
	logic [RPM_W-1:0]   last_rpm  [WHEELS];

	logic [STAMP_W-1:0] next_stamp [WHEELS];

	rpm_report_t pending_reports [$];
	int          fail_cnt;
	int          stuck_cnt;
	int          send_idle_pct;
	int          recv_stall_pct;

	stim_row_t dir_rows [19] = '{
		'{ACTION_CAPTURE, 2'd0, 16'h0000, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd0, 16'h03E8, 1'b0, 1'b0, NO_RPM},
		'{ACTION_TICK,    2'd0, 16'h0000, 1'b1, 1'b1, '{16'hFFFF, 16'h0, 16'h0, 16'h0}},
		'{ACTION_CAPTURE, 2'd1, 16'h0064, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd1, 16'h0064, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd2, 16'hFFFF, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd2, 16'h9C40, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd3, 16'hFFFF, 1'b0, 1'b0, NO_RPM},
		'{ACTION_TICK,    2'd3, 16'hFFFF, 1'b0, 1'b0, NO_RPM},
		'{ACTION_TICK,    2'd0, 16'h0000, 1'b1, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd3, 16'h1111, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd3, 16'h2222, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd3, 16'h3333, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd3, 16'h4444, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd3, 16'h5555, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd3, 16'h0000, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd3, 16'hC000, 1'b0, 1'b0, NO_RPM},
		'{ACTION_CAPTURE, 2'd3, 16'hFFFF, 1'b0, 1'b0, NO_RPM},
		'{ACTION_TICK,    2'd2, 16'h5A5A, 1'b0, 1'b0, NO_RPM}
	};

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit predict_rpm_report(input stim_row_t it, output rpm_report_t rep);
		logic [STAMP_W-1:0] period;
		logic [NUM_W-1:0]   quo;
		logic [RPM_W-1:0]   gap;
		bit                 fire;
		int                 w;
		fire = 1'b0;
		rep = '0;
		if (it.action == ACTION_CAPTURE) begin
			if (stamp_cnt[it.wheel] < CAPTURE_DEPTH) begin
				stamp_old[it.wheel] = stamp_new[it.wheel];
				stamp_new[it.wheel] = it.stamp;
				stamp_cnt[it.wheel] = stamp_cnt[it.wheel] + 1'b1;
			end
			return 1'b0;
		end
		for (w = 0; w < WHEELS; w++) begin
			if (stamp_cnt[w] >= 2) begin
				period = stamp_new[w] - stamp_old[w];
				if (period == '0) begin
					wheel_rpm[w] = '1;
				end else begin
					quo = numer_cfg / {{(NUM_W-STAMP_W){1'b0}}, period};
					wheel_rpm[w] = (quo > 32'h0000_FFFF) ? '1 : quo[RPM_W-1:0];
				end
				quiet_cnt[w] = '0;
				stamp_cnt[w] = '0;
			end else if (quiet_cnt[w] <= stall_cfg) begin
				if (quiet_cnt[w] != '1)
					quiet_cnt[w] = quiet_cnt[w] + 1'b1;
			end else begin
				wheel_rpm[w] = '0;
				quiet_cnt[w] = '0;
				stamp_cnt[w] = '0;
			end
		end
		for (w = 0; w < WHEELS; w++) begin
			gap = (wheel_rpm[w] >= last_rpm[w]) ? wheel_rpm[w] - last_rpm[w]
				: last_rpm[w] - wheel_rpm[w];
			if (gap >= min_chg_cfg)
				fire = 1'b1;
		end
		if (fire) begin
			for (w = 0; w < WHEELS; w++)
				last_rpm[w] = wheel_rpm[w];
			rep = '{wheel_rpm[0], wheel_rpm[1], wheel_rpm[2], wheel_rpm[3]};
		end
		return fire;
	endfunction

	task automatic send_item(input stim_row_t it);
		rpm_report_t rep;
		bit          fire;
		while ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(negedge clk);
		end
		in_if.valid     <= 1'b1;
		in_if.action    <= it.action;
		in_if.wheel     <= it.wheel;
		in_if.timestamp <= it.stamp;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		fire = predict_rpm_report(it, rep);
		if (it.typed) begin
			fire = it.report;
			rep = it.rpm;
		end
		if (fire)
			pending_reports.push_back(rep);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			CFG_RPM_NUMERATOR: numer_cfg = value[NUM_W-1:0];
			CFG_STALL_TICKS: stall_cfg = value[STALL_W-1:0];
			CFG_MIN_CHANGE: min_chg_cfg = value[RPM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic reconfigure(input logic [NUM_W-1:0] numer, input logic [STALL_W-1:0] stall,
		input logic [RPM_W-1:0] min_chg);
		wait_drained();
		write_reg(CFG_RPM_NUMERATOR, numer);
		write_reg(CFG_STALL_TICKS, {{(CFG_DATA_W-STALL_W){1'b0}}, stall});
		write_reg(CFG_MIN_CHANGE, {{(CFG_DATA_W-RPM_W){1'b0}}, min_chg});
		cfg_if.valid <= 1'b0;
	endtask

	// A sparse stream keeps the rear right wheel silent long enough for its
	// quiet count to reach its ceiling.
	task automatic run_random(input int n_items, input bit sparse);
		stim_row_t it;
		int        ncap [WHEELS];
		int        sent;
		int        left;
		int        w;
		int        r;
		sent = 0;
		while (sent < n_items) begin
			if (!sparse && $urandom_range(99) < 10) begin
				it = '0;
				it.action = 1'($urandom_range(1));
				it.wheel = WHEEL_W'($urandom_range(3));
				it.stamp = STAMP_W'($urandom_range(16'hFFFF));
				send_item(it);
				sent++;
			end else begin
				left = 0;
				for (w = 0; w < WHEELS; w++) begin
					r = $urandom_range(99);
					if (sparse)
						ncap[w] = (w != WHEELS - 1 && r < 5) ? 2 : 0;
					else if (r < 35)
						ncap[w] = 0;
					else if (r < 50)
						ncap[w] = 1;
					else if (r < 90)
						ncap[w] = $urandom_range(3, 2);
					else
						ncap[w] = $urandom_range(10, 7);
					left += ncap[w];
				end
				while (left > 0) begin
					w = $urandom_range(WHEELS - 1);
					if (ncap[w] > 0) begin
						ncap[w]--;
						left--;
						r = $urandom_range(99);
						if (r < 10)
							next_stamp[w] = next_stamp[w];
						else if (r < 25)
							next_stamp[w] = next_stamp[w] + STAMP_W'($urandom_range(4, 1));
						else
							next_stamp[w] = next_stamp[w] + STAMP_W'($urandom_range(16'hFFFF));
						it = '0;
						it.action = ACTION_CAPTURE;
						it.wheel = WHEEL_W'(w);
						it.stamp = next_stamp[w];
						send_item(it);
						sent++;
					end
				end
				it = '0;
				it.action = ACTION_TICK;
				it.wheel = WHEEL_W'($urandom_range(3));
				it.stamp = STAMP_W'($urandom_range(16'hFFFF));
				send_item(it);
				sent++;
			end
		end
		in_if.valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [RPM_W-1:0] want,
		input logic [RPM_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	always @(negedge clk)
		out_if.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		rpm_report_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (pending_reports.size() == 0) begin
				$error("report with none expected: %0d %0d %0d %0d", out_if.rpm_fl,
					out_if.rpm_fr, out_if.rpm_rl, out_if.rpm_rr);
				fail_cnt++;
			end else begin
				want = pending_reports.pop_front();
				check_field("rpm_fl", want.fl, out_if.rpm_fl);
				check_field("rpm_fr", want.fr, out_if.rpm_fr);
				check_field("rpm_rl", want.rl, out_if.rpm_rl);
				check_field("rpm_rr", want.rr, out_if.rpm_rr);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
			|| (cfg_if.valid && cfg_if.ready)) begin
			stuck_cnt <= 0;
		end else begin
			stuck_cnt <= stuck_cnt + 1;
			if (stuck_cnt + 1 >= STUCK_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		in_if.valid = 1'b0;
		in_if.action = ACTION_CAPTURE;
		in_if.wheel = '0;
		in_if.timestamp = '0;
		out_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_RPM_NUMERATOR;
		cfg_if.data = '0;
		arst_n = 1'b0;
		numer_cfg = RPM_NUMERATOR_RESET;
		stall_cfg = STALL_TICKS_RESET;
		min_chg_cfg = MIN_CHANGE_RESET;
		for (int w = 0; w < WHEELS; w++) begin
			stamp_cnt[w] = '0;
			stamp_new[w] = '0;
			stamp_old[w] = '0;
			quiet_cnt[w] = '0;
			wheel_rpm[w] = '0;
			last_rpm[w] = '0;
			next_stamp[w] = STAMP_W'($urandom_range(16'hFFFF));
		end
		send_idle_pct = 25;
		recv_stall_pct = 80;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i]);
		in_if.valid <= 1'b0;

		reconfigure('0, '0, '0);
		run_random(100, 1'b0);
		reconfigure('1, '1, '0);
		run_random(420, 1'b1);

		send_idle_pct = 80;
		recv_stall_pct = 25;
		reconfigure($urandom_range(20_000_000, 100_000), 8'd3, 16'd1);
		run_random(110, 1'b0);
		reconfigure($urandom, STALL_W'($urandom_range(12)), '1);
		run_random(100, 1'b0);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		reconfigure($urandom_range(50_000_000, 100_000), STALL_W'($urandom_range(8)),
			RPM_W'($urandom_range(300)));
		run_random(100, 1'b0);
		reconfigure(RPM_NUMERATOR_RESET, STALL_TICKS_RESET, MIN_CHANGE_RESET);
		run_random(100, 1'b0);

		wait_drained();
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
